>>> hdl/blob_statistics_table_core_assert.svh
// assertion macros shared by the blob statistics checker
`ifndef BLOB_STATISTICS_TABLE_CORE_ASSERT_SVH
`define BLOB_STATISTICS_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BST_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("blob statistics assertion failed");

// next-cycle implication, disabled while reset is held
`define BST_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blob statistics assertion failed");

`endif

>>> hdl/bst_pkg.sv
// types and constants of the blob statistics table
`timescale 1ns / 1ps

package bst_pkg;

    // table size and field widths
    localparam int LABELS = 64;
    localparam int LBL_W  = $clog2(LABELS);
    localparam int X_W    = 9;
    localparam int Y_W    = 8;
    localparam int AREA_W = 17;
    localparam int SUM_W  = 25;
    localparam int CNT_W  = 4;

    // image size, area saturation limit and reset values of the object size limits
    localparam logic [X_W-1:0]    IMG_WIDTH      = 9'd320;
    localparam logic [Y_W-1:0]    IMG_HEIGHT     = 8'd240;
    localparam logic [AREA_W-1:0] AREA_MAX       = 17'h1FFFF;
    localparam logic [AREA_W-1:0] MIN_SIZE_RESET = 17'd100;
    localparam logic [AREA_W-1:0] MAX_SIZE_RESET = 17'd76700;

    // configuration register indexes
    localparam logic CFG_MIN_IDX = 1'b0;
    localparam logic CFG_MAX_IDX = 1'b1;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_ACC   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUT
    } state_t;

    // one table entry as held in memory
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  col_sum;
        logic [SUM_W-1:0]  row_sum;
        logic [X_W-1:0]    left;
        logic [X_W-1:0]    right;
        logic [Y_W-1:0]    top;
        logic [Y_W-1:0]    bottom;
    } bst_entry_t;

    // divider control
    typedef struct packed {
        logic start;
        logic sel_y;
    } bst_div_ctl_t;

endpackage

>>> hdl/blob_statistics_table_core.sv
// per-label blob statistics table with bounding box and centroid readout
//
//  channel  direction  handshake          contents
//  s_       in         s_valid / s_ready  func, pixel column and row, label
//  m_       out        m_valid / m_ready  label, area, box, centroid, object flag
//  cfg_     in         cfg_we             min and max object size
//
// accumulate, clear and unused codes pass through accept, then table lookup and write.
// a read passes through accept, lookup, the bit-serial divider (column then row centroid)
// and output load; an empty or background read skips the divider.
// s_ready is high only between items; the output load waits while a result beat is stalled.
// reset empties the whole table at once through per-label valid bits; no clearing pass.
`timescale 1ns / 1ps

module blob_statistics_table_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [bst_pkg::X_W-1:0]     s_pix_x,
    input  logic [bst_pkg::Y_W-1:0]     s_pix_y,
    input  logic [bst_pkg::LBL_W-1:0]   s_label_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bst_pkg::LBL_W-1:0]   m_read_label,
    output logic [bst_pkg::AREA_W-1:0]  m_area,
    output logic [bst_pkg::X_W-1:0]     m_box_left,
    output logic [bst_pkg::X_W-1:0]     m_box_right,
    output logic [bst_pkg::Y_W-1:0]     m_box_top,
    output logic [bst_pkg::Y_W-1:0]     m_box_bottom,
    output logic [bst_pkg::X_W-1:0]     m_center_x,
    output logic [bst_pkg::Y_W-1:0]     m_center_y,
    output logic                        m_is_object,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [bst_pkg::AREA_W-1:0]  cfg_wdata
);
    import bst_pkg::*;

    state_t              state_reg, state_next;
    logic [LABELS-1:0]   valid_reg, valid_next;
    logic [AREA_W-1:0]   min_reg, min_next;
    logic [AREA_W-1:0]   max_reg, max_next;
    logic                m_valid_reg, m_valid_next;

    func_t               func_reg, func_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [LBL_W-1:0]    lab_reg, lab_next;
    bst_entry_t          entry_reg, entry_next;
    logic [X_W-1:0]      cx_reg, cx_next;
    logic [Y_W-1:0]      cy_reg, cy_next;

    logic [LBL_W-1:0]    m_label_reg, m_label_next;
    logic [AREA_W-1:0]   m_area_reg, m_area_next;
    logic [X_W-1:0]      m_left_reg, m_left_next;
    logic [X_W-1:0]      m_right_reg, m_right_next;
    logic [Y_W-1:0]      m_top_reg, m_top_next;
    logic [Y_W-1:0]      m_bottom_reg, m_bottom_next;
    logic [X_W-1:0]      m_cx_reg, m_cx_next;
    logic [Y_W-1:0]      m_cy_reg, m_cy_next;
    logic                m_obj_reg, m_obj_next;

    logic                ram_we;
    bst_entry_t          ram_rdata;
    bst_entry_t          entry_cur;
    bst_entry_t          acc_entry;
    logic                lab_ok;
    logic                acc_ok;
    logic                first_pix;
    logic [SUM_W:0]      col_ext;
    logic [SUM_W:0]      row_ext;

    bst_div_ctl_t        div_ctl;
    logic [SUM_W-1:0]    div_dividend;
    logic [AREA_W-1:0]   div_divisor;
    logic [X_W-1:0]      div_quotient;
    logic                div_done;

    // statistics memory, read every cycle at the incoming label
    bst_ram #(
        .WIDTH ($bits(bst_entry_t)),
        .DEPTH (LABELS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (lab_reg),
        .wdata (acc_entry),
        .raddr (s_label_id),
        .rdata (ram_rdata)
    );

    // shared centroid divider
    bst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // entry as seen by this item; a label never written reads as empty
    assign entry_cur = valid_reg[lab_reg] ? ram_rdata : '0;
    assign lab_ok    = lab_reg != '0;
    assign first_pix = entry_cur.area == '0;
    assign acc_ok    = lab_ok && (x_reg < IMG_WIDTH) && (y_reg < IMG_HEIGHT)
                       && (entry_cur.area != AREA_MAX);

    // accumulate update: saturating sums, box set on first pixel then widened
    assign col_ext = {1'b0, entry_cur.col_sum} + (SUM_W + 1)'(x_reg);
    assign row_ext = {1'b0, entry_cur.row_sum} + (SUM_W + 1)'(y_reg);

    always_comb begin
        acc_entry.area    = entry_cur.area + 1'b1;
        acc_entry.col_sum = col_ext[SUM_W] ? '1 : col_ext[SUM_W-1:0];
        acc_entry.row_sum = row_ext[SUM_W] ? '1 : row_ext[SUM_W-1:0];
        acc_entry.left    = (first_pix || x_reg < entry_cur.left)    ? x_reg : entry_cur.left;
        acc_entry.right   = (first_pix || x_reg > entry_cur.right)   ? x_reg : entry_cur.right;
        acc_entry.top     = (first_pix || y_reg < entry_cur.top)     ? y_reg : entry_cur.top;
        acc_entry.bottom  = (first_pix || y_reg > entry_cur.bottom)  ? y_reg : entry_cur.bottom;
    end

    // sequencer: next state, table control, divider control, output load
    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        func_next     = func_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        lab_next      = lab_reg;
        entry_next    = entry_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        m_label_next  = m_label_reg;
        m_area_next   = m_area_reg;
        m_left_next   = m_left_reg;
        m_right_next  = m_right_reg;
        m_top_next    = m_top_reg;
        m_bottom_next = m_bottom_reg;
        m_cx_next     = m_cx_reg;
        m_cy_next     = m_cy_reg;
        m_obj_next    = m_obj_reg;
        ram_we        = 1'b0;
        div_ctl       = '0;
        div_dividend  = entry_reg.row_sum;
        div_divisor   = entry_reg.area;

        // configuration writes
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MIN_IDX: min_next = cfg_wdata;
                CFG_MAX_IDX: max_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = func_t'(s_func);
                    x_next     = s_pix_x;
                    y_next     = s_pix_y;
                    lab_next   = s_label_id;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_IDLE;
                unique case (func_reg)
                    FUNC_ACC: begin
                        if (acc_ok) begin
                            ram_we              = 1'b1;
                            valid_next[lab_reg] = 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        if (lab_ok) begin
                            valid_next[lab_reg] = 1'b0;
                        end
                    end
                    FUNC_READ: begin
                        cx_next = '0;
                        cy_next = '0;
                        if (lab_ok && !first_pix) begin
                            entry_next    = entry_cur;
                            div_ctl.start = 1'b1;
                            div_ctl.sel_y = 1'b0;
                            div_dividend  = entry_cur.col_sum;
                            div_divisor   = entry_cur.area;
                            state_next    = ST_DIV_X;
                        end else begin
                            entry_next = '0;
                            state_next = ST_OUT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV_X: begin
                if (div_done) begin
                    cx_next       = div_quotient;
                    div_ctl.start = 1'b1;
                    div_ctl.sel_y = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    cy_next    = div_quotient[Y_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_label_next  = lab_reg;
                    m_area_next   = entry_reg.area;
                    m_left_next   = entry_reg.left;
                    m_right_next  = entry_reg.right;
                    m_top_next    = entry_reg.top;
                    m_bottom_next = entry_reg.bottom;
                    m_cx_next     = cx_reg;
                    m_cy_next     = cy_reg;
                    m_obj_next    = (entry_reg.area > min_reg) && (entry_reg.area < max_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            min_reg     <= MIN_SIZE_RESET;
            max_reg     <= MAX_SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        lab_reg      <= lab_next;
        entry_reg    <= entry_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        m_label_reg  <= m_label_next;
        m_area_reg   <= m_area_next;
        m_left_reg   <= m_left_next;
        m_right_reg  <= m_right_next;
        m_top_reg    <= m_top_next;
        m_bottom_reg <= m_bottom_next;
        m_cx_reg     <= m_cx_next;
        m_cy_reg     <= m_cy_next;
        m_obj_reg    <= m_obj_next;
    end

    // port drive
    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_read_label = m_label_reg;
    assign m_area       = m_area_reg;
    assign m_box_left   = m_left_reg;
    assign m_box_right  = m_right_reg;
    assign m_box_top    = m_top_reg;
    assign m_box_bottom = m_bottom_reg;
    assign m_center_x   = m_cx_reg;
    assign m_center_y   = m_cy_reg;
    assign m_is_object  = m_obj_reg;

endmodule

>>> hdl/bst_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bst_div.sv
// bit-serial restoring divider for the centroid, one quotient bit per cycle
`timescale 1ns / 1ps

module bst_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bst_pkg::bst_div_ctl_t     ctl,
    input  logic [bst_pkg::SUM_W-1:0]  dividend,
    input  logic [bst_pkg::AREA_W-1:0] divisor,
    output logic [bst_pkg::X_W-1:0]    quotient,
    output logic                      done
);
    import bst_pkg::*;

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dvs_reg, dvs_next;
    logic [X_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   diff;
    logic             fits;

    // trial subtract of the shifted divisor
    assign diff = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign fits = !diff[SUM_W];

    // load on start, then one step per cycle
    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            rem_next  = dividend;
            q_next    = '0;
            busy_next = 1'b1;
            if (ctl.sel_y) begin
                dvs_next = SUM_W'(divisor) << (Y_W - 1);
                cnt_next = CNT_W'(Y_W - 1);
            end else begin
                dvs_next = SUM_W'(divisor) << (X_W - 1);
                cnt_next = CNT_W'(X_W - 1);
            end
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = diff[SUM_W-1:0];
            end
            q_next   = {q_reg[X_W-2:0], fits};
            dvs_next = dvs_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

>>> hdl/bst_checker.sv
// port-level checker for the blob statistics table and its bind
`timescale 1ns / 1ps

`include "blob_statistics_table_core_assert.svh"

module bst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_read_label,
    input logic [16:0] m_area,
    input logic [8:0]  m_box_left,
    input logic [8:0]  m_box_right,
    input logic [7:0]  m_box_top,
    input logic [7:0]  m_box_bottom,
    input logic [8:0]  m_center_x,
    input logic [7:0]  m_center_y,
    input logic        m_is_object
);

    // a stalled result beat holds
    `BST_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_area) && $stable(m_read_label) && $stable(m_center_x))

    // one item at a time: ready drops after an accepted beat
    `BST_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

    // empty entries and background read as all zero
    `BST_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && (m_area == 17'd0 || m_read_label == 6'd0), m_area == 17'd0 && m_box_left == 9'd0 && m_box_right == 9'd0 && m_box_top == 8'd0 && m_box_bottom == 8'd0 && m_center_x == 9'd0 && m_center_y == 8'd0 && !m_is_object)

    // a filled entry has an ordered bounding box
    `BST_ASSERT_NOW(a_box_order, aclk, aresetn, m_valid && m_area != 17'd0, m_box_left <= m_box_right && m_box_top <= m_box_bottom)

endmodule

bind blob_statistics_table_core bst_checker u_bst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_label (m_read_label),
    .m_area       (m_area),
    .m_box_left   (m_box_left),
    .m_box_right  (m_box_right),
    .m_box_top    (m_box_top),
    .m_box_bottom (m_box_bottom),
    .m_center_x   (m_center_x),
    .m_center_y   (m_center_y),
    .m_is_object  (m_is_object)
);

>>> tb/sv/tb.sv
// self-checking testbench for the blob statistics table core
`timescale 1ns / 1ps

module tb;
    import bst_pkg::*;

    // func code 3 has no meaning in the block and must be dropped
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [AREA_W-1:0] SIZE_TOP = 17'd76800;
    localparam int DRAIN_CYCLES = 30;

    // one read beat as seen on the result channel
    typedef struct packed {
        logic [LBL_W-1:0]  read_label;
        logic [AREA_W-1:0] area;
        logic [X_W-1:0]    box_left;
        logic [X_W-1:0]    box_right;
        logic [Y_W-1:0]    box_top;
        logic [Y_W-1:0]    box_bottom;
        logic [X_W-1:0]    center_x;
        logic [Y_W-1:0]    center_y;
        logic              is_object;
    } blob_stats_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_func;
    logic [X_W-1:0]    s_pix_x;
    logic [Y_W-1:0]    s_pix_y;
    logic [LBL_W-1:0]  s_label_id;
    logic              m_valid;
    logic              m_ready;
    logic [LBL_W-1:0]  m_read_label;
    logic [AREA_W-1:0] m_area;
    logic [X_W-1:0]    m_box_left;
    logic [X_W-1:0]    m_box_right;
    logic [Y_W-1:0]    m_box_top;
    logic [Y_W-1:0]    m_box_bottom;
    logic [X_W-1:0]    m_center_x;
    logic [Y_W-1:0]    m_center_y;
    logic              m_is_object;
    logic              cfg_we;
    logic              cfg_addr;
    logic [AREA_W-1:0] cfg_wdata;

    // shadow copy of the label table and the size limits
    bst_entry_t        label_tab [LABELS];
    logic [AREA_W-1:0] size_lo;
    logic [AREA_W-1:0] size_hi;

    blob_stats_t pending_reads [$];
    int unsigned bad_count;
    bit          src_gaps;
    bit          snk_stalls;

    blob_statistics_table_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_pix_x      (s_pix_x),
        .s_pix_y      (s_pix_y),
        .s_label_id   (s_label_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_label (m_read_label),
        .m_area       (m_area),
        .m_box_left   (m_box_left),
        .m_box_right  (m_box_right),
        .m_box_top    (m_box_top),
        .m_box_bottom (m_box_bottom),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y),
        .m_is_object  (m_is_object),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 15);
        else return $urandom_range(16, 60);
    endfunction

    // saturating add of one coordinate into a 25 bit sum
    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] s,
                                                 input logic [X_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(v);
        return t[SUM_W] ? '1 : t[SUM_W-1:0];
    endfunction

    // apply one item to the shadow table; returns 1 when a read beat is due
    function automatic bit stats_update(input logic [1:0] fn, input logic [X_W-1:0] x,
                                        input logic [Y_W-1:0] y,
                                        input logic [LBL_W-1:0] lbl,
                                        output blob_stats_t res);
        bst_entry_t       e;
        bit               lbl_ok;
        logic [SUM_W-1:0] q;
        lbl_ok = (lbl != '0) && (int'(lbl) < LABELS);
        res = '0;
        case (fn)
            FUNC_ACC: begin
                e = label_tab[lbl];
                if (lbl_ok && x < IMG_WIDTH && y < IMG_HEIGHT && e.area != AREA_MAX) begin
                    if (e.area == '0) begin
                        e.left = x;
                        e.right = x;
                        e.top = y;
                        e.bottom = y;
                    end else begin
                        if (x < e.left) e.left = x;
                        if (x > e.right) e.right = x;
                        if (y < e.top) e.top = y;
                        if (y > e.bottom) e.bottom = y;
                    end
                    e.col_sum = sum_sat(e.col_sum, x);
                    e.row_sum = sum_sat(e.row_sum, {1'b0, y});
                    e.area = e.area + 1'b1;
                    label_tab[lbl] = e;
                end
                return 1'b0;
            end
            FUNC_CLEAR: begin
                if (lbl_ok) label_tab[lbl] = '0;
                return 1'b0;
            end
            FUNC_READ: begin
                e = label_tab[lbl];
                res.read_label = lbl;
                if (lbl_ok && e.area != '0) begin
                    res.area = e.area;
                    res.box_left = e.left;
                    res.box_right = e.right;
                    res.box_top = e.top;
                    res.box_bottom = e.bottom;
                    q = e.col_sum / {{(SUM_W-AREA_W){1'b0}}, e.area};
                    res.center_x = q[X_W-1:0];
                    q = e.row_sum / {{(SUM_W-AREA_W){1'b0}}, e.area};
                    res.center_y = q[Y_W-1:0];
                    res.is_object = (e.area > size_lo) && (e.area < size_hi);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // drive one input beat and wait for it to be taken
    task automatic send_item(input logic [1:0] fn, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input logic [LBL_W-1:0] lbl);
        int unsigned gap;
        blob_stats_t res;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_pix_x <= x;
        s_pix_y <= y;
        s_label_id <= lbl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (stats_update(fn, x, y, lbl, res)) pending_reads = {pending_reads, res};
    endtask

    // let every read come back and the last table write settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write both size limits, only while the block is idle
    task automatic set_limits(input logic [AREA_W-1:0] lo, input logic [AREA_W-1:0] hi);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_MIN_IDX;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_addr <= CFG_MAX_IDX;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we <= 1'b0;
        size_lo = lo;
        size_hi = hi;
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got, input logic [LBL_W-1:0] lbl);
        if (got !== want) begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t label %0d %s: expected %0d, got %0d",
                         $realtime, lbl, fname, want, got);
        end
    endtask

    // result checker: each read beat against the oldest prediction
    always @(posedge aclk) begin : result_check
        blob_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t unexpected read beat for label %0d", $realtime, m_read_label);
            end else begin
                want = pending_reads.pop_front();
                cmp_field("read_label", 32'(want.read_label), 32'(m_read_label),
                          want.read_label);
                cmp_field("area", 32'(want.area), 32'(m_area), want.read_label);
                cmp_field("box_left", 32'(want.box_left), 32'(m_box_left), want.read_label);
                cmp_field("box_right", 32'(want.box_right), 32'(m_box_right),
                          want.read_label);
                cmp_field("box_top", 32'(want.box_top), 32'(m_box_top), want.read_label);
                cmp_field("box_bottom", 32'(want.box_bottom), 32'(m_box_bottom),
                          want.read_label);
                cmp_field("center_x", 32'(want.center_x), 32'(m_center_x), want.read_label);
                cmp_field("center_y", 32'(want.center_y), 32'(m_center_y), want.read_label);
                cmp_field("is_object", 32'(want.is_object), 32'(m_is_object),
                          want.read_label);
            end
        end
    end

    // result side back-pressure
    initial begin : sink_ready
        int unsigned hold;
        m_ready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (snk_stalls && $urandom_range(0, 2) == 0) hold = pick_gap();
            end
        end
    end

    // object flag under the limits that reset leaves behind
    task automatic test_reset_limits();
        int i;
        send_item(FUNC_CLEAR, '0, '0, 6'd20);
        for (i = 0; i < 100; i++)
            send_item(FUNC_ACC, X_W'(i * 3), Y_W'(i * 2), 6'd20);
        send_item(FUNC_READ, '0, '0, 6'd20);
        send_item(FUNC_ACC, 9'd5, 8'd7, 6'd20);
        send_item(FUNC_READ, '0, '0, 6'd20);
        wait_idle();
    endtask

    // empty entries, background, spare code, box growth, off-image pixels, clear
    task automatic test_directed_cases();
        send_item(FUNC_READ, '0, '0, 6'd1);
        send_item(FUNC_READ, '0, '0, 6'd63);
        send_item(FUNC_READ, '0, '0, 6'd0);
        send_item(FUNC_ACC, 9'd10, 8'd10, 6'd0);
        send_item(FUNC_CLEAR, '0, '0, 6'd0);
        send_item(FUNC_READ, '0, '0, 6'd0);
        send_item(FUNC_SPARE, 9'd511, 8'd255, 6'd63);
        send_item(FUNC_ACC, 9'd319, 8'd239, 6'd63);
        send_item(FUNC_ACC, 9'd0, 8'd0, 6'd1);
        send_item(FUNC_READ, '0, '0, 6'd63);
        send_item(FUNC_READ, '0, '0, 6'd1);
        send_item(FUNC_ACC, 9'd100, 8'd50, 6'd5);
        send_item(FUNC_ACC, 9'd90, 8'd60, 6'd5);
        send_item(FUNC_ACC, 9'd120, 8'd40, 6'd5);
        send_item(FUNC_ACC, 9'd320, 8'd50, 6'd5);
        send_item(FUNC_ACC, 9'd100, 8'd240, 6'd5);
        send_item(FUNC_ACC, 9'd511, 8'd255, 6'd5);
        send_item(FUNC_READ, '0, '0, 6'd5);
        send_item(FUNC_CLEAR, '0, '0, 6'd5);
        send_item(FUNC_READ, '0, '0, 6'd5);
        send_item(FUNC_ACC, 9'd200, 8'd200, 6'd5);
        send_item(FUNC_READ, '0, '0, 6'd5);
        send_item(FUNC_CLEAR, '0, '0, 6'd63);
        send_item(FUNC_READ, '0, '0, 6'd63);
        wait_idle();
    endtask

    // object flag at the limit extremes and right at the boundaries
    task automatic test_flag_limits();
        logic [AREA_W-1:0] lo_set [6];
        logic [AREA_W-1:0] hi_set [6];
        int k;
        lo_set = '{17'd0, SIZE_TOP, 17'd1, 17'd0, 17'd2, SIZE_TOP};
        hi_set = '{SIZE_TOP, 17'd0, 17'd3, 17'd2, 17'd2, SIZE_TOP};
        send_item(FUNC_ACC, 9'd1, 8'd1, 6'd10);
        send_item(FUNC_ACC, 9'd2, 8'd2, 6'd11);
        send_item(FUNC_ACC, 9'd4, 8'd3, 6'd11);
        send_item(FUNC_ACC, 9'd300, 8'd200, 6'd12);
        send_item(FUNC_ACC, 9'd301, 8'd201, 6'd12);
        send_item(FUNC_ACC, 9'd310, 8'd230, 6'd12);
        wait_idle();
        for (k = 0; k < 6; k++) begin
            set_limits(lo_set[k], hi_set[k]);
            send_item(FUNC_READ, '0, '0, 6'd10);
            send_item(FUNC_READ, '0, '0, 6'd11);
            send_item(FUNC_READ, '0, '0, 6'd12);
            send_item(FUNC_READ, '0, '0, 6'd13);
            wait_idle();
        end
    endtask

    // random traffic in phases, each with its own limits and idling
    task automatic test_random_traffic();
        logic [LBL_W-1:0]  pool [4];
        int unsigned       px [4];
        int unsigned       py [4];
        logic [AREA_W-1:0] lo;
        logic [AREA_W-1:0] hi;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        int unsigned       sent;
        int unsigned       r;
        int                k;
        int                n;
        sent = 0;
        while (sent < 1340) begin
            case ($urandom_range(0, 7))
                0: begin lo = '0; hi = SIZE_TOP; end
                1: begin lo = SIZE_TOP; hi = '0; end
                2: begin
                    lo = AREA_W'($urandom_range(0, 76800));
                    hi = AREA_W'($urandom_range(0, 76800));
                end
                default: begin
                    lo = AREA_W'($urandom_range(0, 40));
                    hi = lo + AREA_W'($urandom_range(0, 80));
                end
            endcase
            set_limits(lo, hi);
            src_gaps = ($urandom_range(0, 3) != 0);
            snk_stalls = ($urandom_range(0, 3) != 0);
            for (k = 0; k < 4; k++) begin
                pool[k] = LBL_W'($urandom_range(1, 63));
                px[k] = $urandom_range(0, 304);
                py[k] = $urandom_range(0, 224);
            end
            for (n = $urandom_range(60, 150); n > 0; n--) begin
                k = $urandom_range(0, 3);
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // pixel of a blob: mostly clustered, sometimes anywhere
                    if ($urandom_range(0, 2) == 0) begin
                        x = X_W'($urandom_range(0, 319));
                        y = Y_W'($urandom_range(0, 239));
                    end else begin
                        x = X_W'(px[k] + $urandom_range(0, 15));
                        y = Y_W'(py[k] + $urandom_range(0, 15));
                    end
                    send_item(FUNC_ACC, x, y, pool[k]);
                end else if (r < 80) begin
                    send_item(FUNC_READ, X_W'($urandom), Y_W'($urandom), pool[k]);
                end else if (r < 84) begin
                    send_item(FUNC_CLEAR, X_W'($urandom), Y_W'($urandom), pool[k]);
                end else if (r < 88) begin
                    // off-image pixel
                    if ($urandom_range(0, 1) == 0)
                        send_item(FUNC_ACC, X_W'($urandom_range(320, 511)), Y_W'($urandom),
                                  pool[k]);
                    else
                        send_item(FUNC_ACC, X_W'($urandom_range(0, 319)),
                                  Y_W'($urandom_range(240, 255)), pool[k]);
                end else if (r < 91) begin
                    send_item(($urandom_range(0, 1) == 0) ? FUNC_ACC : FUNC_CLEAR,
                              X_W'($urandom), Y_W'($urandom), '0);
                end else if (r < 93) begin
                    send_item(FUNC_SPARE, X_W'($urandom), Y_W'($urandom), LBL_W'($urandom));
                end else begin
                    send_item(FUNC_READ, X_W'($urandom), Y_W'($urandom),
                              LBL_W'($urandom_range(0, 63)));
                end
                sent++;
            end
            wait_idle();
        end
        src_gaps = 1'b0;
        snk_stalls = 1'b0;
    endtask

    // run limit
    initial begin
        #25_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_ACC;
        s_pix_x = '0;
        s_pix_y = '0;
        s_label_id = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_MIN_IDX;
        cfg_wdata = '0;
        size_lo = MIN_SIZE_RESET;
        size_hi = MAX_SIZE_RESET;
        bad_count = 0;
        src_gaps = 1'b1;
        snk_stalls = 1'b1;
        foreach (label_tab[k]) label_tab[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_limits();
        test_directed_cases();
        test_flag_limits();
        test_random_traffic();

        if (bad_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/bst_pkg.sv
hdl/bst_ram.sv
hdl/bst_div.sv
hdl/blob_statistics_table_core.sv
hdl/bst_checker.sv
tb/sv/tb.sv
